// File: hdl/crs_pkg.sv
// Shared constants and codes for the circle raster stepper.
package crs_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CX_W        = 12;
  localparam int unsigned CY_W        = 12;
  localparam int unsigned RAD_W       = 11;
  localparam int unsigned OUT_W       = 14;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned S_TUSER_W   = MODE_W;
  localparam int unsigned M_TDATA_W   = 4 * OUT_W;
  localparam int unsigned M_TUSER_W   = 2;

  // Default geometry and queue size.
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned RADIUS_BITS_DEF = 11;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Midpoint decision constants.
  localparam int unsigned DEC_INIT     = 3;
  localparam int unsigned DEC_DIAG     = 10;
  localparam int unsigned DEC_STRAIGHT = 6;

  // Item kinds carried on the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_OUTLINE = 2'd0,
    MODE_FILL    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_ADV_ALT = 2'd3
  } mode_e;

endpackage

// File: hdl/crs_front.sv
// Front end: accepts items, keeps the circle state and queues one step record per item.
module crs_front #(
  parameter int unsigned COORD_BITS  = crs_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = crs_pkg::RADIUS_BITS_DEF,
  parameter int unsigned REC_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [crs_pkg::MODE_W-1:0] mode_i,
  input  logic [crs_pkg::CX_W-1:0]   center_x_i,
  input  logic [crs_pkg::CY_W-1:0]   center_y_i,
  input  logic [crs_pkg::RAD_W-1:0]  radius_i,
  output logic                       push_o,
  output logic [REC_W-1:0]           push_data_o
);

  localparam int unsigned XW = RADIUS_BITS + 1;
  localparam int unsigned YW = RADIUS_BITS + 2;
  localparam int unsigned DW = RADIUS_BITS + 5;

  logic [COORD_BITS-1:0]   center_col_q, center_col_d;
  logic [COORD_BITS-1:0]   center_row_q, center_row_d;
  logic [XW-1:0]           step_x_q, step_x_d;
  logic signed [YW-1:0]    step_y_q, step_y_d;
  logic signed [DW-1:0]    decision_q, decision_d;
  logic                    fill_mode_q, fill_mode_d;
  logic                    active_q, active_d;

  logic                    is_start;
  logic [RADIUS_BITS-1:0]  rad;
  logic [XW-1:0]           x_adv;
  logic signed [YW-1:0]    y_adv;
  logic signed [DW-1:0]    xd, yd, rd, d_diag, d_straight;
  logic signed [YW-1:0]    x_cmp;
  logic                    done;
  logic                    empty;

  assign is_start = (mode_i == crs_pkg::MODE_OUTLINE) || (mode_i == crs_pkg::MODE_FILL);
  assign rad      = RADIUS_BITS'(radius_i);

  // One midpoint decision update.
  assign x_adv      = step_x_q + XW'(1);
  assign y_adv      = (decision_q > 0) ? (step_y_q - YW'(1)) : step_y_q;
  assign xd         = signed'(DW'(x_adv));
  assign yd         = DW'(y_adv);
  assign rd         = signed'(DW'(rad));
  assign d_diag     = decision_q + ((xd - yd) <<< 2) + DW'(crs_pkg::DEC_DIAG);
  assign d_straight = decision_q + (xd <<< 2) + DW'(crs_pkg::DEC_STRAIGHT);
  assign x_cmp      = signed'(YW'(x_adv));

  // Next state and step record for the accepted item.
  always_comb begin
    center_col_d = center_col_q;
    center_row_d = center_row_q;
    step_x_d     = step_x_q;
    step_y_d     = step_y_q;
    decision_d   = decision_q;
    fill_mode_d  = fill_mode_q;
    active_d     = active_q;
    done         = 1'b0;
    empty        = 1'b0;
    if (is_start) begin
      // A start always leaves y at or above x, so it never finishes at once.
      center_col_d = COORD_BITS'(center_x_i);
      center_row_d = COORD_BITS'(center_y_i);
      fill_mode_d  = (mode_i == crs_pkg::MODE_FILL);
      step_x_d     = '0;
      step_y_d     = signed'(YW'(rad));
      decision_d   = DW'(crs_pkg::DEC_INIT) - (rd <<< 1);
      active_d     = 1'b1;
    end else if (!active_q) begin
      empty = 1'b1;
      done  = 1'b1;
    end else begin
      step_x_d   = x_adv;
      step_y_d   = y_adv;
      decision_d = (decision_q > 0) ? d_diag : d_straight;
      done       = (y_adv < x_cmp);
      active_d   = !(y_adv < x_cmp);
    end
  end

  assign push_o      = accept_i;
  assign push_data_o = {empty, done, fill_mode_d, step_y_d, step_x_d,
                        center_row_d, center_col_d};

  // Circle state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= '0;
      center_row_q <= '0;
      step_x_q     <= '0;
      step_y_q     <= '0;
      decision_q   <= '0;
      fill_mode_q  <= 1'b0;
      active_q     <= 1'b0;
    end else if (accept_i) begin
      center_col_q <= center_col_d;
      center_row_q <= center_row_d;
      step_x_q     <= step_x_d;
      step_y_q     <= step_y_d;
      decision_q   <= decision_d;
      fill_mode_q  <= fill_mode_d;
      active_q     <= active_d;
    end
  end

endmodule

// File: hdl/crs_queue.sv
// Short first-in first-out queue of step records between front and back.
module crs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = crs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  // Storage is written only on a push.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: hdl/crs_back.sv
// Back end: expands one step record into mirrored points or spans, one transfer per cycle unless stalled.
module crs_back #(
  parameter int unsigned COORD_BITS  = crs_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = crs_pkg::RADIUS_BITS_DEF,
  parameter int unsigned REC_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [REC_W-1:0]              rec_i,
  input  logic                          rec_empty_i,
  output logic                          pop_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [crs_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                          m_tlast_o,
  output logic [crs_pkg::M_TUSER_W-1:0] m_tuser_o
);

  localparam int unsigned XW  = RADIUS_BITS + 1;
  localparam int unsigned YW  = RADIUS_BITS + 2;
  localparam int unsigned NW  = ((COORD_BITS + 1 > YW) ? COORD_BITS + 1 : YW) + 1;
  localparam int unsigned WW  = (NW > crs_pkg::OUT_W) ? NW : crs_pkg::OUT_W;
  localparam int unsigned OW  = crs_pkg::OUT_W;

  logic [REC_W-1:0]       cur_q;
  logic                   cur_valid_q;
  logic [2:0]             idx_q;

  logic [COORD_BITS-1:0]  cx, cy;
  logic [XW-1:0]          sx;
  logic signed [YW-1:0]   sy;
  logic                   fill, done, empty;

  logic                   advance, last, swap, rneg, cneg;
  logic signed [WW-1:0]   cxw, cyw, xw, yw, a, b, col0, col1, row;
  logic [OW-1:0]          x0, x1, y0;

  logic                   out_valid_q;
  logic [crs_pkg::M_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;
  logic [crs_pkg::M_TUSER_W-1:0] out_user_q;

  assign {empty, done, fill, sy, sx, cy, cx} = cur_q;

  // Which mirror image the current result is.
  always_comb begin
    if (empty) begin
      last = 1'b1;
    end else if (fill) begin
      last = (idx_q[1:0] == 2'b11);
    end else begin
      last = (idx_q == 3'b111);
    end
  end
  assign swap = fill ? idx_q[1] : idx_q[2];
  assign rneg = fill ? idx_q[0] : idx_q[1];
  assign cneg = fill ? 1'b0 : idx_q[0];

  // Span coordinates around the center, wrapped to the output width.
  assign cxw  = signed'(WW'(cx));
  assign cyw  = signed'(WW'(cy));
  assign xw   = signed'(WW'(sx));
  assign yw   = WW'(sy);
  assign a    = swap ? yw : xw;
  assign b    = swap ? xw : yw;
  assign col0 = cneg ? (cxw - a) : (cxw + a);
  assign col1 = fill ? (cxw - a) : col0;
  assign row  = rneg ? (cyw - b) : (cyw + b);
  assign x0   = empty ? '0 : col0[OW-1:0];
  assign x1   = empty ? '0 : col1[OW-1:0];
  assign y0   = empty ? '0 : row[OW-1:0];

  // A result moves into the output register when it is free or being drained.
  assign advance = cur_valid_q && (!out_valid_q || m_tready_i);
  assign pop_o   = !rec_empty_i && (!cur_valid_q || (advance && last));

  // Current record and result index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (advance) begin
        cur_valid_q <= !last;
        idx_q       <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= rec_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {y0, x1, y0, x0};
      out_last_q <= last;
      out_user_q <= {empty, done};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_user_q;

endmodule

// File: hdl/circle_raster_stepper_unit.sv
// Top level of the midpoint circle rasterizer: front end, step queue and span emitter.
// The first result of an item passes through the step queue, the current-record register and the output register.
// An outline step yields eight results, a fill step four and an idle advance one;
// the output port carries one result per cycle while m_axis_tready stays high.
// Input transfers continue back to back while the two-entry step queue has room.
// Reset (rst_ni low, asynchronous) clears the circle state to idle and empties the queue.
module circle_raster_stepper_unit #(
  parameter int unsigned COORD_BITS  = crs_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = crs_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_x [11:0], center_y [23:12], radius [34:24], zero [39:35]
  input  logic [crs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode [1:0]
  input  logic [crs_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // span_x0 [13:0], span_y0 [27:14], span_x1 [41:28], span_y0 again [55:42]
  output logic [crs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last_of_step
  output logic                          m_axis_tlast,
  // done_res [0], empty_res [1]
  output logic [crs_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  localparam int unsigned REC_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 6;
  localparam int unsigned CY_LO = crs_pkg::CX_W;
  localparam int unsigned RD_LO = crs_pkg::CX_W + crs_pkg::CY_W;

  logic             accept;
  logic             push;
  logic [REC_W-1:0] push_data;
  logic             pop;
  logic [REC_W-1:0] pop_data;
  logic             q_full;
  logic             q_empty;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Item classification and decision update.
  crs_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .REC_W       (REC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (s_axis_tuser),
    .center_x_i  (s_axis_tdata[crs_pkg::CX_W-1:0]),
    .center_y_i  (s_axis_tdata[CY_LO +: crs_pkg::CY_W]),
    .radius_i    (s_axis_tdata[RD_LO +: crs_pkg::RAD_W]),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Step records waiting for the emitter.
  crs_queue #(
    .WIDTH (REC_W),
    .DEPTH (crs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Point and span generation.
  crs_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .REC_W       (REC_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (pop_data),
    .rec_empty_i (q_empty),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
